/* design/bti_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// bti_pkg
// Shared types and constants of the breakpoint table interpolator.
// ---------------------------------------------------------------------------
package bti_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned Depth   = 64;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned CountW  = 7;
  localparam int unsigned DiffW   = DataW + 1;
  localparam int unsigned FracW   = 16;
  localparam int unsigned QuoW    = DiffW + FracW;
  localparam int unsigned SliceW  = 17;
  localparam int unsigned Slices  = 3;
  localparam int unsigned AccW    = QuoW + DiffW;
  localparam int unsigned DeltaW  = 41;
  localparam int unsigned CntW    = 6;

  localparam logic [QuoW-1:0] OneQ16      = QuoW'(65536);
  localparam logic [QuoW-1:0] FactorLoMag = QuoW'(655);
  localparam logic [QuoW-1:0] FactorHi    = QuoW'(66191);

  localparam logic OpWrite  = 1'b0;
  localparam logic OpLookup = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK0,
    ST_CHK1,
    ST_DOWN,
    ST_UP,
    ST_LD0,
    ST_LD1,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_e;

endpackage
`default_nettype wire

/* design/breakpoint_table_interpolator.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// breakpoint_table_interpolator
// Piecewise linear lookup over a 64-entry table of Q16.16 breakpoints.
// ---------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries one word per item: a
// write loads key and value into a slot, a lookup gives a key. The output
// channel (out_valid_o / out_stall_i) returns one word per item; writes
// return zeros. cfg_we_i / cfg_wdata_i set the number of breakpoints in use.
// One item is worked on at a time; in_stall_o is high while it is busy.
// A write goes straight to the final step after acceptance. A lookup passes
// through the start check, a check of the key above the start segment when
// needed, the segment walk over the breakpoints stepped over (one key memory
// read per cycle from a registered read port), the load of both breakpoints,
// the bit-serial divide that forms the factor and the sliced multiply in three
// slices. A zero-width segment skips the divide.
// The next item is accepted the cycle after the result is loaded.
// The result is held in an output register; a stalled result blocks only
// the final step, so the next item may be accepted meanwhile.
// Reset clears control state, sets the entry count to 2 and the last
// segment to 1; table contents are undefined until written.
// ---------------------------------------------------------------------------
module breakpoint_table_interpolator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic                          operation_i,
  input  wire logic [bti_pkg::IdxW-1:0]      entry_index_i,
  input  wire logic signed [bti_pkg::DataW-1:0] entry_key_i,
  input  wire logic signed [bti_pkg::DataW-1:0] entry_value_i,
  input  wire logic signed [bti_pkg::DataW-1:0] lookup_key_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic signed [bti_pkg::DataW-1:0] result_value_o,
  output      logic                          in_range_o,
  output      logic [bti_pkg::IdxW-1:0]      segment_index_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [bti_pkg::CountW-1:0]    cfg_wdata_i
);

  localparam int unsigned DataW  = bti_pkg::DataW;
  localparam int unsigned IdxW   = bti_pkg::IdxW;
  localparam int unsigned CountW = bti_pkg::CountW;
  localparam int unsigned DiffW  = bti_pkg::DiffW;
  localparam int unsigned QuoW   = bti_pkg::QuoW;
  localparam int unsigned SliceW = bti_pkg::SliceW;
  localparam int unsigned AccW   = bti_pkg::AccW;
  localparam int unsigned DeltaW = bti_pkg::DeltaW;
  localparam int unsigned CntW   = bti_pkg::CntW;
  localparam int unsigned PadW   = SliceW * bti_pkg::Slices;

  bti_pkg::state_e state_q, state_d;

  logic [CountW-1:0] entries_q;
  logic [IdxW-1:0]   last_seg_q;
  logic [IdxW-1:0]   r_q, r_d;
  logic [CountW-1:0] n_q, n_d;
  logic              op_q;
  logic signed [DataW-1:0] key_q, k0_q, v0_q;
  logic [DiffW-1:0]  span_mag_q, dv_mag_q;
  logic              f_sign_q, dv_neg_q;
  logic [DiffW-1:0]  rem_q;
  logic [QuoW-1:0]   quo_q;
  logic [CntW-1:0]   cnt_q;
  logic [AccW-1:0]   acc_q;

  logic signed [DataW-1:0] key_mem [bti_pkg::Depth];
  logic signed [DataW-1:0] val_mem [bti_pkg::Depth];
  logic signed [DataW-1:0] key_rd_q, val_rd_q;
  logic [IdxW-1:0]   rd_addr;
  logic              mem_we;

  logic              in_acc, out_free;
  logic [CountW-1:0] n_clamp;
  logic [IdxW-1:0]   r_clamp;
  logic [CountW-1:0] n_m1;
  logic              can_down, can_up;

  logic signed [DiffW-1:0] dk_s, span_s, dv_s;
  logic [DiffW-1:0]  dk_mag, span_mag;
  logic [DiffW:0]    rem_sh;
  logic              quo_bit;
  logic [PadW-1:0]   f_pad;
  logic [SliceW-1:0] f_slice;
  logic [AccW-1:0]   acc_next;

  logic [AccW-17:0]  prod_sh;
  logic [DeltaW-1:0] mag;
  logic              f_neg, d_neg, in_rng;
  logic signed [DeltaW:0] delta, res_w;
  logic signed [DataW-1:0] res_sat;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_o || !out_stall_i;
  assign in_stall_o = (state_q != bti_pkg::ST_IDLE);
  assign mem_we   = in_acc && (operation_i == bti_pkg::OpWrite);

  assign n_clamp = (entries_q < CountW'(2)) ? CountW'(2) :
                   (entries_q > CountW'(bti_pkg::Depth)) ? CountW'(bti_pkg::Depth) : entries_q;
  always_comb begin
    if ({1'b0, last_seg_q} >= n_clamp) begin
      r_clamp = IdxW'(n_clamp - CountW'(1));
    end else if (last_seg_q == '0) begin
      r_clamp = IdxW'(1);
    end else begin
      r_clamp = last_seg_q;
    end
  end

  assign n_m1     = n_q - CountW'(1);
  assign can_down = (r_q > IdxW'(1)) && (key_rd_q > key_q);
  assign can_up   = ({1'b0, r_q} < n_m1);

  // difference terms, taken as the upper breakpoint arrives
  assign dk_s     = DiffW'(key_q) - DiffW'(k0_q);
  assign span_s   = DiffW'(key_rd_q) - DiffW'(k0_q);
  assign dv_s     = DiffW'(val_rd_q) - DiffW'(v0_q);
  assign dk_mag   = dk_s[DiffW-1] ? DiffW'(-dk_s) : DiffW'(dk_s);
  assign span_mag = span_s[DiffW-1] ? DiffW'(-span_s) : DiffW'(span_s);

  // restoring divide, one quotient bit per cycle
  assign rem_sh  = {rem_q, quo_q[QuoW-1]};
  assign quo_bit = (rem_sh >= {1'b0, span_mag_q});

  // sliced multiply, most significant slice first
  assign f_pad    = PadW'(quo_q);
  always_comb begin
    case (cnt_q)
      CntW'(0): f_slice = f_pad[PadW-1 -: SliceW];
      CntW'(1): f_slice = f_pad[PadW-SliceW-1 -: SliceW];
      default:  f_slice = f_pad[SliceW-1:0];
    endcase
  end
  assign acc_next = (acc_q << SliceW) + AccW'(dv_mag_q * f_slice);

  assign prod_sh = acc_q[AccW-1:16];
  assign mag     = (prod_sh > (AccW-16)'(1) << 40) ? DeltaW'(1) << 40 : DeltaW'(prod_sh);
  assign f_neg   = f_sign_q && (quo_q != '0);
  assign d_neg   = f_neg != dv_neg_q;
  assign delta   = d_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign res_w   = (DeltaW+1)'(v0_q) + delta;
  always_comb begin
    if (res_w > (DeltaW+1)'($signed({1'b0, {(DataW-1){1'b1}}}))) begin
      res_sat = {1'b0, {(DataW-1){1'b1}}};
    end else if (res_w < -(DeltaW+1)'($signed({1'b0, 1'b1, {(DataW-1){1'b0}}}))) begin
      res_sat = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      res_sat = DataW'(res_w);
    end
  end
  assign in_rng = f_neg ? (quo_q <= bti_pkg::FactorLoMag) : (quo_q <= bti_pkg::FactorHi);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bti_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (operation_i == bti_pkg::OpWrite) ? bti_pkg::ST_FIN : bti_pkg::ST_CHK0;
        end
      end
      bti_pkg::ST_CHK0: begin
        if (can_down) begin
          state_d = bti_pkg::ST_DOWN;
        end else if (can_up) begin
          state_d = bti_pkg::ST_CHK1;
        end else begin
          state_d = bti_pkg::ST_LD0;
        end
      end
      bti_pkg::ST_CHK1: state_d = (key_rd_q < key_q) ? bti_pkg::ST_UP : bti_pkg::ST_LD0;
      bti_pkg::ST_DOWN: state_d = can_down ? bti_pkg::ST_DOWN : bti_pkg::ST_LD0;
      bti_pkg::ST_UP:   state_d = (can_up && key_rd_q <= key_q) ? bti_pkg::ST_UP : bti_pkg::ST_LD0;
      bti_pkg::ST_LD0:  state_d = bti_pkg::ST_LD1;
      bti_pkg::ST_LD1:  state_d = (span_s == '0) ? bti_pkg::ST_MUL : bti_pkg::ST_DIV;
      bti_pkg::ST_DIV:  state_d = (cnt_q == CntW'(QuoW-1)) ? bti_pkg::ST_MUL : bti_pkg::ST_DIV;
      bti_pkg::ST_MUL:  state_d = (cnt_q == CntW'(bti_pkg::Slices-1)) ? bti_pkg::ST_FIN : bti_pkg::ST_MUL;
      bti_pkg::ST_FIN:  state_d = out_free ? bti_pkg::ST_IDLE : bti_pkg::ST_FIN;
      default:          state_d = bti_pkg::ST_IDLE;
    endcase
  end

  // read address and walk pointer
  always_comb begin
    r_d     = r_q;
    n_d     = n_q;
    rd_addr = r_q - IdxW'(1);
    unique case (state_q)
      bti_pkg::ST_IDLE: begin
        n_d     = n_clamp;
        r_d     = r_clamp;
        rd_addr = r_clamp - IdxW'(1);
      end
      bti_pkg::ST_CHK0: begin
        if (can_down) begin
          r_d     = r_q - IdxW'(1);
          rd_addr = r_q - IdxW'(2);
        end else if (can_up) begin
          rd_addr = r_q;
        end
      end
      bti_pkg::ST_CHK1: begin
        if (key_rd_q < key_q) begin
          r_d     = r_q + IdxW'(1);
          rd_addr = r_q + IdxW'(1);
        end
      end
      bti_pkg::ST_DOWN: begin
        if (can_down) begin
          r_d     = r_q - IdxW'(1);
          rd_addr = r_q - IdxW'(2);
        end
      end
      bti_pkg::ST_UP: begin
        if (can_up && key_rd_q <= key_q) begin
          r_d     = r_q + IdxW'(1);
          rd_addr = r_q + IdxW'(1);
        end
      end
      bti_pkg::ST_LD0: rd_addr = r_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[entry_index_i] <= entry_key_i;
      val_mem[entry_index_i] <= entry_value_i;
    end
    key_rd_q <= key_mem[rd_addr];
    val_rd_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bti_pkg::ST_IDLE;
      entries_q   <= CountW'(2);
      last_seg_q  <= IdxW'(1);
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        entries_q <= cfg_wdata_i;
      end
      if (state_q == bti_pkg::ST_LD0) begin
        last_seg_q <= r_q;
      end
      if (state_q == bti_pkg::ST_FIN && out_free) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    n_q <= n_d;
    unique case (state_q)
      bti_pkg::ST_IDLE: begin
        op_q  <= operation_i;
        key_q <= lookup_key_i;
      end
      bti_pkg::ST_LD0: begin
        k0_q <= key_rd_q;
        v0_q <= val_rd_q;
      end
      bti_pkg::ST_LD1: begin
        span_mag_q <= span_mag;
        dv_mag_q   <= dv_s[DiffW-1] ? DiffW'(-dv_s) : DiffW'(dv_s);
        dv_neg_q   <= dv_s[DiffW-1];
        f_sign_q   <= (span_s != '0) && (dk_s[DiffW-1] != span_s[DiffW-1]);
        rem_q      <= '0;
        quo_q      <= (span_s == '0) ? bti_pkg::OneQ16 : {dk_mag, 16'd0};
        cnt_q      <= '0;
        acc_q      <= '0;
      end
      bti_pkg::ST_DIV: begin
        rem_q <= quo_bit ? DiffW'(rem_sh - {1'b0, span_mag_q}) : DiffW'(rem_sh);
        quo_q <= {quo_q[QuoW-2:0], quo_bit};
        cnt_q <= (cnt_q == CntW'(QuoW-1)) ? '0 : cnt_q + CntW'(1);
      end
      bti_pkg::ST_MUL: begin
        acc_q <= acc_next;
        cnt_q <= cnt_q + CntW'(1);
      end
      bti_pkg::ST_FIN: begin
        if (out_free) begin
          result_value_o  <= (op_q == bti_pkg::OpWrite) ? '0 : res_sat;
          in_range_o      <= (op_q == bti_pkg::OpWrite) ? 1'b0 : in_rng;
          segment_index_o <= (op_q == bti_pkg::OpWrite) ? '0 : r_q;
        end
      end
      default: ;
    endcase
  end

  a_last_seg_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_seg_q != '0)
    else $error("last segment pointer is zero");

  a_walk_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bti_pkg::ST_DOWN || state_q == bti_pkg::ST_UP) |->
      (r_q != '0 && {1'b0, r_q} < n_q))
    else $error("segment walk left the table");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bti_pkg::ST_DIV |-> span_mag_q != '0)
    else $error("divide by zero-width segment");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == bti_pkg::ST_FIN))
    else $error("result word raised outside final step");

endmodule
`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Breakpoint table interpolator testbench
// Loads tables of ascending and unordered breakpoints, looks up keys inside
// and beyond the table, and checks every result word against a local
// piecewise linear predictor. The input idles and the receiver stalls at random.
// ---------------------------------------------------------------------------
module testbench;

  localparam int unsigned DataW  = bti_pkg::DataW;
  localparam int unsigned IdxW   = bti_pkg::IdxW;
  localparam int unsigned CountW = bti_pkg::CountW;
  localparam int unsigned Depth  = bti_pkg::Depth;
  localparam logic OpWrite  = bti_pkg::OpWrite;
  localparam logic OpLookup = bti_pkg::OpLookup;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 200;
  localparam int unsigned RandomItems   = 1400;

  typedef struct packed {
    logic              op;
    logic [IdxW-1:0]   idx;
    logic [DataW-1:0]  ekey;
    logic [DataW-1:0]  eval;
    logic [DataW-1:0]  lkey;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             in_range;
    logic [IdxW-1:0]  seg;
  } answer_t;

  typedef struct {
    item_t   it;
    logic    known;
    answer_t ans;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic operation_i;
  logic [IdxW-1:0] entry_index_i;
  logic signed [DataW-1:0] entry_key_i;
  logic signed [DataW-1:0] entry_value_i;
  logic signed [DataW-1:0] lookup_key_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [DataW-1:0] result_value_o;
  logic in_range_o;
  logic [IdxW-1:0] segment_index_o;
  logic cfg_we_i;
  logic [CountW-1:0] cfg_wdata_i;

  breakpoint_table_interpolator dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .operation_i,
    .entry_index_i,
    .entry_key_i,
    .entry_value_i,
    .lookup_key_i,
    .out_valid_o,
    .out_stall_i,
    .result_value_o,
    .in_range_o,
    .segment_index_o,
    .cfg_we_i,
    .cfg_wdata_i
  );

  // predictor state
  logic signed [DataW-1:0] bp_key [Depth];
  logic signed [DataW-1:0] bp_val [Depth];
  int unsigned recent_seg;
  int unsigned bp_count;

  answer_t expected_words[$];
  int unsigned fail_count;
  int unsigned idle_cycles;
  int unsigned cyc = 0;
  bit hold_off;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic answer_t interpolate(item_t it);
    answer_t a;
    int unsigned n, r;
    longint key, k0, k1, v0, v1, dk, span, f, dv, res;
    logic [127:0] prod;
    logic [63:0] q, mag;
    a = '0;
    if (it.op == OpWrite) begin
      bp_key[it.idx] = it.ekey;
      bp_val[it.idx] = it.eval;
      return a;
    end
    key = longint'(signed'(it.lkey));
    n = bp_count < 2 ? 2 : (bp_count > Depth ? Depth : bp_count);
    r = recent_seg;
    if (r >= n) r = n - 1;
    else if (r < 1) r = 1;
    if (r > 1 && longint'(bp_key[r-1]) > key) begin
      while (r > 1 && longint'(bp_key[r-1]) > key) r--;
    end else if (r < n - 1 && longint'(bp_key[r]) < key) begin
      while (r < n - 1 && longint'(bp_key[r]) <= key) r++;
    end
    recent_seg = r;
    k0 = bp_key[r-1];
    k1 = bp_key[r];
    v0 = bp_val[r-1];
    v1 = bp_val[r];
    dk = key - k0;
    span = k1 - k0;
    if (span == 0) f = 65536;
    else begin
      q = ((dk < 0 ? -dk : dk) << 16) / (span < 0 ? -span : span);
      f = ((dk < 0) != (span < 0)) ? -longint'(q) : longint'(q);
    end
    dv = v1 - v0;
    prod = 128'(f < 0 ? -f : f) * 128'(dv < 0 ? -dv : dv);
    prod = prod >> 16;
    mag = (prod > 128'(64'd1 << 40)) ? (64'd1 << 40) : prod[63:0];
    res = v0 + (((f < 0) != (dv < 0)) ? -longint'(mag) : longint'(mag));
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    a.value = res[DataW-1:0];
    a.in_range = (f >= -655 && f <= 66191);
    a.seg = r[IdxW-1:0];
    return a;
  endfunction

  // evaluates a row without disturbing predictor state
  function automatic answer_t interpolate_peek(item_t it);
    logic signed [DataW-1:0] sk [Depth];
    logic signed [DataW-1:0] sv [Depth];
    int unsigned sr;
    answer_t a;
    sk = bp_key;
    sv = bp_val;
    sr = recent_seg;
    a = interpolate(it);
    bp_key = sk;
    bp_val = sv;
    recent_seg = sr;
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk_i) begin
    answer_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", {result_value_o, segment_index_o}, 0);
      end else begin
        w = expected_words.pop_front();
        if (result_value_o !== w.value) report_mismatch("result_value", result_value_o, w.value);
        if (in_range_o !== w.in_range) report_mismatch("in_range", in_range_o, w.in_range);
        if (segment_index_o !== w.seg) report_mismatch("segment_index", segment_index_o, w.seg);
      end
    end
    cyc <= cyc + 1;
    if (hold_off) out_stall_i <= 1'b1;
    else if (cyc % 600 < 150) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) == 0);
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // valid stays up after acceptance until the next word or a gap replaces it
  task automatic send_word(item_t it);
    answer_t a;
    if ($urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    a = interpolate(it);
    in_valid_i    <= 1'b1;
    operation_i   <= it.op;
    entry_index_i <= it.idx;
    entry_key_i   <= it.ekey;
    entry_value_i <= it.eval;
    lookup_key_i  <= it.lkey;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_words.insert(expected_words.size(), a);
  endtask

  task automatic set_count(int unsigned n);
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n[CountW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bp_count = n;
  endtask

  function automatic item_t wr(int unsigned i, logic [DataW-1:0] k, logic [DataW-1:0] v);
    item_t it;
    it = '0;
    it.op = OpWrite;
    it.idx = i[IdxW-1:0];
    it.ekey = k;
    it.eval = v;
    it.lkey = $urandom();
    return it;
  endfunction

  function automatic item_t rd(logic [DataW-1:0] k);
    item_t it;
    it = '0;
    it.op = OpLookup;
    it.idx = $urandom();
    it.ekey = $urandom();
    it.eval = $urandom();
    it.lkey = k;
    return it;
  endfunction

  // fills n ascending breakpoints with random spacing
  task automatic load_table(int unsigned n, int unsigned spread);
    longint k;
    k = -longint'($urandom_range(0, spread)) * n / 2;
    if (k < -64'sd2147483648) k = -64'sd2147483648;
    for (int unsigned i = 0; i < n; i++) begin
      send_word(wr(i, k[DataW-1:0], $urandom()));
      k += $urandom_range(0, spread);
      if (k > 64'sd2147483647) k = 64'sd2147483647;
    end
  endtask

  initial begin
    row_t rows[$];
    row_t rw;
    int unsigned n, items;
    logic [DataW-1:0] k;
    fail_count = 0;
    idle_cycles = 0;
    hold_off = 1'b0;
    recent_seg = 1;
    bp_count = 2;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = OpWrite;
    entry_index_i = '0;
    entry_key_i = '0;
    entry_value_i = '0;
    lookup_key_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zero-width segment, extrapolation
    rows.insert(rows.size(), '{wr(0, 32'h0000_0000, 32'h0000_0000), 1, '0});
    rows.insert(rows.size(), '{wr(1, 32'h0001_0000, 32'h0002_0000), 1, '0});
    rows.insert(rows.size(), '{rd(32'h0000_8000), 1, '{32'h0001_0000, 1'b1, 6'd1}});
    rows.insert(rows.size(), '{rd(32'h0000_0000), 1, '{32'h0000_0000, 1'b1, 6'd1}});
    rows.insert(rows.size(), '{rd(32'h0001_0000), 1, '{32'h0002_0000, 1'b1, 6'd1}});
    rows.insert(rows.size(), '{rd(32'h0002_0000), 1, '{32'h0004_0000, 1'b0, 6'd1}});
    rows.insert(rows.size(), '{rd(32'hFFFF_0000), 1, '{32'hFFFE_0000, 1'b0, 6'd1}});
    rows.insert(rows.size(), '{rd(32'h7FFF_FFFF), 0, '0});
    rows.insert(rows.size(), '{rd(32'h8000_0000), 0, '0});
    rows.insert(rows.size(), '{wr(1, 32'h0000_0000, 32'h7FFF_FFFF), 1, '0});
    rows.insert(rows.size(), '{rd(32'h1234_5678), 1, '{32'h7FFF_FFFF, 1'b1, 6'd1}});
    rows.insert(rows.size(), '{wr(0, 32'h8000_0000, 32'h8000_0000), 1, '0});
    rows.insert(rows.size(), '{wr(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1, '0});
    rows.insert(rows.size(), '{rd(32'h0000_0000), 0, '0});
    rows.insert(rows.size(), '{wr(63, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, '0});
    rows.insert(rows.size(), '{wr(1, 32'hC000_0000, 32'h4000_0000), 1, '0});
    rows.insert(rows.size(), '{rd(32'h8000_0000), 0, '0});
    rows.insert(rows.size(), '{rd(32'h7FFF_FFFF), 0, '0});
    foreach (rows[i]) begin
      rw = rows[i];
      if (rw.known && interpolate_peek(rw.it) !== rw.ans)
        report_mismatch("directed row", i, 0);
      send_word(rw.it);
    end

    // full table with the widest count, then a walk across it
    set_count(Depth + 10);
    load_table(Depth, 32'h0100_0000);
    for (int i = 0; i < 20; i++) send_word(rd($urandom()));
    set_count(0);
    send_word(rd($urandom()));

    // long receiver hold-off while items keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_word(rd($urandom()));
    join

    items = 0;
    while (items < RandomItems) begin
      case ($urandom_range(0, 3))
        0: n = Depth;
        1: n = 2;
        default: n = $urandom_range(2, 12);
      endcase
      set_count(n);
      load_table(n, ($urandom_range(0, 1) ? 32'h0000_4000 : 32'h0800_0000));
      items += n;
      for (int i = 0; i < 60; i++) begin
        case ($urandom_range(0, 9))
          0: k = $urandom();
          1: begin
            send_word(wr($urandom_range(0, n - 1), $urandom(), $urandom()));
            items++;
            k = $urandom();
          end
          2: k = bp_key[$urandom_range(0, n - 1)];
          default: k = bp_key[$urandom_range(0, n - 1)] + $urandom_range(0, 32'h0400_0000)
                       - 32'h0200_0000;
        endcase
        send_word(rd(k));
        items++;
      end
    end
    // out-of-range count written between phases
    set_count(7'h7F);
    send_word(rd($urandom()));

    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* breakpoint_table_interpolator.f */
design/bti_pkg.sv
design/breakpoint_table_interpolator.sv
verif/testbench.sv
